// ===== rtl/core/b64e_pkg.sv =====
package b64e_pkg;

  localparam logic [6:0] PAD_CHAR = 7'd61;
  localparam int unsigned JOB_CHARS = 4;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  // position within the three-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // one byte's worth of characters for the back end
  typedef struct packed {
    logic [JOB_CHARS-1:0][6:0] chars;
    logic [1:0]                cnt_m1;
    logic                      fin;
  } job_t;

  // standard alphabet lookup
  function automatic logic [6:0] enc_char(input logic [5:0] v);
    logic [6:0] r;
    r = 7'd0;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd97 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = 7'd48 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  b64e_pkg::in_item_t in_item,
  output logic               job_push,
  output b64e_pkg::job_t     job
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       left_r, left_nxt;
  logic             take;
  logic [7:0]       b;

  assign take     = in_push & ~in_full;
  assign job_push = take;
  assign b        = in_item.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH_0;
      left_r  <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    phase_nxt = b64e_pkg::PH_0;
    left_nxt  = 4'd0;
    job.chars = '{default: b64e_pkg::PAD_CHAR};
    job.cnt_m1 = 2'd0;
    job.fin    = in_item.last_byte;
    unique case (phase_r)
      b64e_pkg::PH_1: begin
        job.chars[0] = b64e_pkg::enc_char({left_r[1:0], b[7:4]});
        if (in_item.last_byte) begin
          job.chars[1] = b64e_pkg::enc_char({b[3:0], 2'b00});
          job.cnt_m1   = 2'd2;
        end else begin
          phase_nxt = b64e_pkg::PH_2;
          left_nxt  = b[3:0];
        end
      end
      b64e_pkg::PH_2: begin
        job.chars[0] = b64e_pkg::enc_char({left_r, b[7:6]});
        job.chars[1] = b64e_pkg::enc_char(b[5:0]);
        job.cnt_m1   = 2'd1;
      end
      default: begin
        job.chars[0] = b64e_pkg::enc_char(b[7:2]);
        if (in_item.last_byte) begin
          job.chars[1] = b64e_pkg::enc_char({b[1:0], 4'b0000});
          job.cnt_m1   = 2'd3;
        end else begin
          phase_nxt = b64e_pkg::PH_1;
          left_nxt  = {2'b00, b[1:0]};
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/b64e_fifo.sv =====
module b64e_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           nonempty,
  output b64e_pkg::job_t rd_job
);

  b64e_pkg::job_t mem_r [b64e_pkg::FIFO_DEPTH];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'(b64e_pkg::FIFO_DEPTH));
  assign nonempty = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      priority if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/b64e_back.sv =====
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  b64e_pkg::job_t      job_in,
  output logic                job_take,
  output logic                out_empty,
  input  logic                out_pop,
  output b64e_pkg::out_item_t out_item
);

  b64e_pkg::job_t      job_r;
  logic                busy_r, busy_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                ov_r, ov_nxt;
  b64e_pkg::out_item_t oi_r, oi_nxt;
  logic                adv, at_end;

  assign at_end    = (idx_r == job_r.cnt_m1);
  assign adv       = busy_r & (~ov_r | out_pop);
  assign job_take  = job_avail & (~busy_r | (adv & at_end));
  assign out_empty = ~ov_r;
  assign out_item  = oi_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    oi_nxt   = oi_r;
    if (adv) begin
      ov_nxt            = 1'b1;
      oi_nxt.out_char   = job_r.chars[idx_r];
      oi_nxt.last_char  = job_r.fin & at_end;
      idx_nxt           = idx_r + 2'd1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
    if (job_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job_in;
    end
    oi_r <= oi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

// ===== rtl/core/base64_stream_encoder_core.sv =====
// path: a byte's first character goes through the job queue, job_r and the output register
// output: a character per cycle while popped or empty; a byte per cycle while the queue has
//   room; a byte gives one or two characters mid-stream and up to four for a final byte
// the single character output register sets the rate
// reset: synchronous active-low rst_n clears group phase, queue and output valid
module base64_stream_encoder_core (
  input  logic                clk,
  input  logic                rst_n,
  // byte input, queue style
  input  logic                in_push,
  output logic                in_full,
  input  b64e_pkg::in_item_t  in_item,
  // character output, queue style
  output logic                out_empty,
  input  logic                out_pop,
  output b64e_pkg::out_item_t out_item
);

  // front to queue
  logic           f_push;
  b64e_pkg::job_t f_job;
  // queue to back
  logic           q_nonempty;
  logic           q_take;
  b64e_pkg::job_t q_job;

  // front: tracks group phase and leftover bits, turns each byte transfer
  // into a job of one to four ready-made ascii characters
  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .job_push (f_push),
    .job      (f_job)
  );

  // short job queue so the front keeps taking bytes while the back drains
  b64e_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_job   (f_job),
    .full     (in_full),
    .rd_en    (q_take),
    .nonempty (q_nonempty),
    .rd_job   (q_job)
  );

  // back: serializes each job one character per cycle into the output register while the
  // output is popped or empty, loading the next job on the cycle the current one finishes
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (q_nonempty),
    .job_in    (q_job),
    .job_take  (q_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== verif/base64_stream_encoder_checker.sv =====
module base64_stream_encoder_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  b64e_pkg::in_item_t  in_item,
  input  logic                out_empty,
  input  logic                out_pop,
  input  b64e_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64e_pkg::out_item_t expected_chars[$];
  b64e_pkg::phase_t    grp_phase;
  logic [3:0]          carry_bits;
  int                  errors;

  function automatic logic [6:0] b64_symbol(input logic [5:0] v);
    logic [7:0] ascii;
    ascii = B64_ALPHABET[8*(63-v) +: 8];
    return ascii[6:0];
  endfunction

  function automatic void queue_char(input logic [6:0] ch, input logic fin);
    b64e_pkg::out_item_t c;
    c.out_char  = ch;
    c.last_char = fin;
    expected_chars.push_back(c);
  endfunction

  // predicted characters for one byte, state advanced in place
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (grp_phase)
      b64e_pkg::PH_1: begin
        queue_char(b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          queue_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b1);
          grp_phase  = b64e_pkg::PH_0;
          carry_bits = 4'd0;
        end else begin
          grp_phase  = b64e_pkg::PH_2;
          carry_bits = b[3:0];
        end
      end
      b64e_pkg::PH_2: begin
        queue_char(b64_symbol({carry_bits, b[7:6]}), 1'b0);
        queue_char(b64_symbol(b[5:0]), fin);
        grp_phase  = b64e_pkg::PH_0;
        carry_bits = 4'd0;
      end
      default: begin
        queue_char(b64_symbol(b[7:2]), 1'b0);
        if (fin) begin
          queue_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b1);
          grp_phase  = b64e_pkg::PH_0;
          carry_bits = 4'd0;
        end else begin
          grp_phase  = b64e_pkg::PH_1;
          carry_bits = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  function automatic void report(input string what, input logic [6:0] exp_v,
                                 input logic [6:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    b64e_pkg::out_item_t want;
    if (!rst_n) begin
      expected_chars.delete();
      grp_phase  = b64e_pkg::PH_0;
      carry_bits = 4'd0;
    end else begin
      // output side first: a character never belongs to a byte taken on the same edge
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, actual %0d/%0b",
                   $realtime, out_item.out_char, out_item.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_item.out_char !== want.out_char) begin
            report("out_char", want.out_char, out_item.out_char);
          end
          if (out_item.last_char !== want.last_char) begin
            report("last_char", {6'd0, want.last_char}, {6'd0, out_item.last_char});
          end
        end
      end
      if (in_push && !in_full) begin
        encode_byte(in_item.data_byte, in_item.last_byte);
      end
    end
    pending    <= expected_chars.size();
    fail_count <= errors;
  end

  initial begin
    errors     = 0;
    grp_phase  = b64e_pkg::PH_0;
    carry_bits = 4'd0;
  end

endmodule

// ===== verif/base64_stream_encoder_core_tb.sv =====
module base64_stream_encoder_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 310;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  b64e_pkg::in_item_t  in_item;
  logic                out_empty;
  logic                out_pop;
  b64e_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending;

  // calm stretches: the side runs with no idle cycles at all
  bit calm_in;
  bit calm_out;
  int bytes_sent;

  base64_stream_encoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  base64_stream_encoder_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_item    (in_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // one byte transfer; called at a falling edge, returns at a falling edge
  // with push still high so back-to-back bytes need no drop of push
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.data_byte <= b;
    in_item.last_byte <= fin;
    in_push           <= 1'b1;
    // transfer happens on the first rising edge that sees full low
    do @(posedge clk); while (in_full);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender drops push and holds off until every predicted character is out
  task automatic drain_wait();
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly random bytes, with the extremes showing up often
  function automatic logic [7:0] draw_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // stimulus side
  initial begin
    int unsigned len;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    calm_in    = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte messages, flush from the start of a group, both pads
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two-byte message, flush from the middle of a group, one pad
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full group ending the message, no pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_wait();
    // complete group then a lone byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // complete group then two bytes
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    // alternating bit patterns, every symbol bit both ways
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
    drain_wait();

    // random messages, mostly short, a few long ones
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 7) == 0) calm_in = !calm_in;
      if ($urandom_range(0, 6) == 0) begin
        len = $urandom_range(10, 40);
      end else begin
        len = $urandom_range(1, 9);
      end
      for (int unsigned i = 1; i <= len; i++) begin
        send_byte(draw_byte(), i == len);
      end
      if ($urandom_range(0, 11) == 0) drain_wait();
    end

    // wind down: all predictions met, then a wait for anything stray
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: random stall before each pop, with calm stretches
  initial begin
    int unsigned stall;
    out_pop  = 1'b0;
    calm_out = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      stall = draw_wait(calm_out);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_fifo.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder_core.sv
verif/base64_stream_encoder_checker.sv
verif/base64_stream_encoder_core_tb.sv
